/* design/dvm_pkg.sv */
// Shared types, codes and fixed-point helpers of the decaying voice mixer.
// Used by the mixer top level and its port checker; depends on nothing.
package dvm_pkg;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_SAMPLE = 2'd1,
        FN_CLOSE  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_STARTED = 3'd0,
        ST_FULL    = 3'd1,
        ST_MIXED   = 3'd2,
        ST_ENDED   = 3'd3,
        ST_IDLE    = 3'd4,
        ST_FRAME   = 3'd5
    } t_status;

    localparam logic [15:0]        MASTER_RESET = 16'd32768;
    localparam logic signed [17:0] GAIN_Q16     = 18'sd45875;
    localparam logic [15:0]        EPS_RAW      = 16'd327;
    localparam logic [24:0]        CLIP_OUT     = 25'd22936;
    localparam logic signed [24:0] ACC_MAX      = 25'sd8388607;
    localparam logic signed [24:0] ACC_MIN      = -25'sd8388608;

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] x,
                                                     input int n);
        logic signed [47:0] half;
        half = 48'sd1 <<< (n - 1);
        if (x >= 0) begin
            rnd_shift = (x + half) >>> n;
        end else begin
            rnd_shift = -(((-x) + half) >>> n);
        end
    endfunction

endpackage

/* design/dvm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; instantiated by the mixer for its voice table.
module dvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/decaying_voice_mixer.sv */
// Stereo voice mixer with per-voice exponential decay over a RAM voice table.
// Depends on dvm_pkg and dvm_ram.
//
//   Channel   Handshake                    Payload
//   input     i_in_valid / o_in_stall      i_func .. i_sample_ok
//   output    o_out_valid / i_out_stall    o_status .. o_active_voices
//   config    i_cfg_we                     i_cfg_wdata (master volume)
//
// A mixing sample beat accepts with the table read and the first product, then reads
// data with decay and the gain product, then the volume product, then commits. A sample
// beat that ends its voice or finds the slot idle skips the volume product.
// A start beat goes through a two-step free-slot search; a close beat goes straight to commit.
// Reset is synchronous, stalls the input while held and clears all valid bits and
// the mix at once. A beat finishes only when the output register is free, so a
// stalled output holds the block after one more beat is accepted.
module decaying_voice_mixer #(
    parameter int VOICES        = 64,
    parameter int POSITION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_slot,
    input  logic [15:0] i_sound_id,
    input  logic [15:0] i_start_volume,
    input  logic [15:0] i_decay_rate,
    input  logic signed [15:0] i_sample_left,
    input  logic signed [15:0] i_sample_right,
    input  logic        i_sample_ok,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_voice_slot,
    output logic [15:0] o_voice_sound,
    output logic [23:0] o_next_position,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic [6:0]  o_active_voices
);
    import dvm_pkg::*;

    localparam int AW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW    = $clog2(VOICES + 1);
    localparam int PB    = POSITION_BITS;
    localparam int REC_W = 64 + PB;
    localparam int G     = (VOICES + 7) / 8;
    localparam int GW    = (G > 1) ? $clog2(G) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND1, S_FIND2, S_READ, S_MUL3, S_DONE
    } t_state;

    t_state  r_state;
    t_status r_res;
    logic [15:0] r_master;
    logic [VOICES-1:0] r_valid;
    logic [CW-1:0] r_count;
    logic signed [23:0] r_mixl, r_mixr;

    logic [5:0]  r_slot;
    logic [AW-1:0] r_wslot;
    logic [15:0] r_sound, r_vol, r_dec;
    logic r_ok;
    logic signed [32:0] r_p1l, r_p1r;
    logic signed [35:0] r_p2l, r_p2r;
    logic signed [34:0] r_p3l, r_p3r;
    logic [15:0] r_lv, r_rv, r_lv_new, r_rv_new, r_rdec;
    logic [PB-1:0] r_pos;
    logic r_grp_free [G];
    logic [2:0] r_grp_idx [G];

    logic r_out_valid;
    t_status r_ostatus;
    logic [5:0]  r_oslot;
    logic [15:0] r_osound;
    logic [23:0] r_opos;
    logic signed [15:0] r_oleft, r_oright;
    logic [6:0]  r_oactive;

    logic [REC_W-1:0] rd_rec, wr_rec;
    logic mem_we;
    logic [15:0] rd_sound, rd_lv, rd_rv, rd_dec;
    logic [PB-1:0] rd_pos;
    logic [31:0] loss_l, loss_r;
    logic [G*8-1:0] busy;
    logic grp_free [G];
    logic [2:0] grp_idx [G];
    logic [GW-1:0] found_grp;
    logic any_free;
    logic accept, out_free;
    logic signed [17:0] t1l, t1r, t2l, t2r;
    logic signed [19:0] cl, cr;
    logic signed [24:0] suml, sumr;
    logic signed [23:0] new_mixl, new_mixr;
    logic slot_bad;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    dvm_ram #(.WIDTH(REC_W), .DEPTH(VOICES)) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wslot),
        .i_wdata (wr_rec),
        .i_raddr (AW'(i_slot)),
        .o_rdata (rd_rec)
    );

    assign rd_sound = rd_rec[REC_W-1 -: 16];
    assign rd_lv    = rd_rec[REC_W-17 -: 16];
    assign rd_rv    = rd_rec[REC_W-33 -: 16];
    assign rd_dec   = rd_rec[REC_W-49 -: 16];
    assign rd_pos   = rd_rec[PB-1:0];
    assign loss_l   = rd_lv * rd_dec;
    assign loss_r   = rd_rv * rd_dec;

    function automatic logic signed [15:0] frame_out(input logic signed [23:0] acc);
        logic [24:0] mag;
        logic [39:0] m;
        logic [24:0] q;
        mag = (acc < 0) ? 25'(-25'(acc)) : 25'(acc);
        m   = ({15'd0, mag} << 15) - {15'd0, mag};
        q   = m[39:15];
        if (q > CLIP_OUT) begin
            q = CLIP_OUT;
        end
        frame_out = (acc < 0) ? 16'(-q) : 16'(q);
    endfunction

    always_comb begin
        busy = '1;
        busy[VOICES-1:0] = r_valid;
        for (int g = 0; g < G; g++) begin
            grp_free[g] = ~&busy[g*8 +: 8];
            grp_idx[g]  = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (!busy[g*8 + b]) begin
                    grp_idx[g] = 3'(b);
                end
            end
        end
        found_grp = '0;
        any_free  = 1'b0;
        for (int g = G - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                found_grp = GW'(g);
                any_free  = 1'b1;
            end
        end
    end

    always_comb begin
        slot_bad = (32'(r_slot) >= 32'(VOICES)) || !r_valid[AW'(r_slot)];
        t1l = 18'(rnd_shift(48'(r_p1l), 15));
        t1r = 18'(rnd_shift(48'(r_p1r), 15));
        t2l = 18'(rnd_shift(48'(r_p2l), 16));
        t2r = 18'(rnd_shift(48'(r_p2r), 16));
        cl  = 20'(rnd_shift(48'(r_p3l), 15));
        cr  = 20'(rnd_shift(48'(r_p3r), 15));
        suml = 25'(r_mixl) + 25'(cl);
        sumr = 25'(r_mixr) + 25'(cr);
        new_mixl = (suml > ACC_MAX) ? 24'(ACC_MAX) :
                   (suml < ACC_MIN) ? 24'(ACC_MIN) : 24'(suml);
        new_mixr = (sumr > ACC_MAX) ? 24'(ACC_MAX) :
                   (sumr < ACC_MIN) ? 24'(ACC_MIN) : 24'(sumr);
        if (r_res == ST_STARTED) begin
            wr_rec = {r_sound, r_vol, r_vol, r_dec, PB'(0)};
        end else begin
            wr_rec = {r_sound, r_lv_new, r_rv_new, r_rdec, r_pos + PB'(1)};
        end
        mem_we = (r_state == S_DONE) && out_free &&
                 (r_res == ST_STARTED || r_res == ST_MIXED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_master    <= MASTER_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_mixl      <= '0;
            r_mixr      <= '0;
            r_out_valid <= 1'b0;
            r_res       <= ST_IDLE;
        end else begin
            if (i_cfg_we) begin
                r_master <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_slot  <= i_slot;
                        r_wslot <= AW'(i_slot);
                        r_sound <= i_sound_id;
                        r_vol   <= i_start_volume;
                        r_dec   <= i_decay_rate;
                        r_ok    <= i_sample_ok;
                        r_p1l   <= i_sample_left * $signed({1'b0, r_master});
                        r_p1r   <= i_sample_right * $signed({1'b0, r_master});
                        case (t_func'(i_func))
                            FN_START:  r_state <= S_FIND1;
                            FN_SAMPLE: r_state <= S_READ;
                            FN_CLOSE: begin
                                r_res   <= ST_FRAME;
                                r_state <= S_DONE;
                            end
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FIND1: begin
                    r_grp_free <= grp_free;
                    r_grp_idx  <= grp_idx;
                    r_state    <= S_FIND2;
                end
                S_FIND2: begin
                    r_wslot <= AW'({found_grp, r_grp_idx[found_grp]});
                    r_res   <= any_free ? ST_STARTED : ST_FULL;
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_sound  <= rd_sound;
                    r_lv     <= rd_lv;
                    r_rv     <= rd_rv;
                    r_rdec   <= rd_dec;
                    r_pos    <= rd_pos;
                    r_lv_new <= rd_lv - loss_l[31:16];
                    r_rv_new <= rd_rv - loss_r[31:16];
                    r_p2l    <= t1l * GAIN_Q16;
                    r_p2r    <= t1r * GAIN_Q16;
                    if (slot_bad) begin
                        r_res   <= ST_IDLE;
                        r_state <= S_DONE;
                    end else if (!r_ok || (rd_lv <= EPS_RAW && rd_rv <= EPS_RAW)) begin
                        r_res   <= ST_ENDED;
                        r_state <= S_DONE;
                    end else begin
                        r_res   <= ST_MIXED;
                        r_state <= S_MUL3;
                    end
                end
                S_MUL3: begin
                    r_p3l   <= t2l * $signed({1'b0, r_lv});
                    r_p3r   <= t2r * $signed({1'b0, r_rv});
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ostatus <= r_res;
                        case (r_res)
                            ST_STARTED: begin
                                r_valid[r_wslot] <= 1'b1;
                                r_count          <= r_count + CW'(1);
                                r_oactive        <= 7'(r_count + CW'(1));
                                r_oslot          <= 6'(r_wslot);
                                r_osound         <= r_sound;
                                r_opos           <= '0;
                                r_oleft          <= '0;
                                r_oright         <= '0;
                            end
                            ST_MIXED: begin
                                r_mixl    <= new_mixl;
                                r_mixr    <= new_mixr;
                                r_oactive <= 7'(r_count);
                                r_oslot   <= r_slot;
                                r_osound  <= r_sound;
                                r_opos    <= 24'(r_pos + PB'(1));
                                r_oleft   <= '0;
                                r_oright  <= '0;
                            end
                            ST_ENDED: begin
                                r_valid[r_wslot] <= 1'b0;
                                if (r_count != '0) begin
                                    r_count   <= r_count - CW'(1);
                                    r_oactive <= 7'(r_count - CW'(1));
                                end else begin
                                    r_oactive <= 7'(r_count);
                                end
                                r_oslot  <= r_slot;
                                r_osound <= r_sound;
                                r_opos   <= 24'(r_pos);
                                r_oleft  <= '0;
                                r_oright <= '0;
                            end
                            ST_IDLE: begin
                                r_oactive <= 7'(r_count);
                                r_oslot   <= r_slot;
                                r_osound  <= '0;
                                r_opos    <= '0;
                                r_oleft   <= '0;
                                r_oright  <= '0;
                            end
                            ST_FRAME: begin
                                r_oactive <= 7'(r_count);
                                r_oslot   <= '0;
                                r_osound  <= '0;
                                r_opos    <= '0;
                                r_oleft   <= frame_out(r_mixl);
                                r_oright  <= frame_out(r_mixr);
                                r_mixl    <= '0;
                                r_mixr    <= '0;
                            end
                            default: begin
                                r_oactive <= 7'(r_count);
                                r_oslot   <= '0;
                                r_osound  <= '0;
                                r_opos    <= '0;
                                r_oleft   <= '0;
                                r_oright  <= '0;
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_ostatus;
    assign o_voice_slot    = r_oslot;
    assign o_voice_sound   = r_osound;
    assign o_next_position = r_opos;
    assign o_out_left      = r_oleft;
    assign o_out_right     = r_oright;
    assign o_active_voices = r_oactive;

endmodule

/* design/dvm_checker.sv */
// Port-level checks on the decaying voice mixer, bound to its top level.
// Depends on dvm_pkg for the function and status codes.
module dvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_func,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [5:0]  o_voice_slot,
    input logic [15:0] o_voice_sound,
    input logic [23:0] o_next_position,
    input logic signed [15:0] o_out_left,
    input logic signed [15:0] o_out_right
);
    import dvm_pkg::*;

    logic acc;
    assign acc = i_in_valid && !o_in_stall;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_func != FN_NONE |=> o_in_stall)
        else $error("input not stalled while a beat is in work");

    a_ignored_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_func == FN_NONE |=> !o_in_stall)
        else $error("ignored beat stalled the input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled output beat changed");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FRAME |->
            o_voice_slot == '0 && o_voice_sound == '0 && o_next_position == '0)
        else $error("frame beat carries voice fields");

    a_voice_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FRAME |-> o_out_left == '0 && o_out_right == '0)
        else $error("voice beat carries frame samples");

endmodule

bind decaying_voice_mixer dvm_checker u_dvm_checker (.*);
